/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the decoder RTL top level.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, ignored while reset is high.
`define SFD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same check, with an explicit antecedent and a consequent checked in the following cycle.
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/sfd_pkg.sv */
// ---------------------------------------------------------------------------
// sfd_pkg
// Types and constants shared by the frame decoder modules.
// ---------------------------------------------------------------------------
package sfd_pkg;

   localparam int FRAME_BYTES  = 25;
   localparam int STORE_DEPTH  = FRAME_BYTES - 2;  // body bytes between start and end byte
   localparam int DATA_BYTES   = STORE_DEPTH - 1;  // packed channel bytes
   localparam int CHANNEL_BITS = 11;
   localparam int BYTE_BITS    = 8;

   localparam int COUNT_W = $clog2(STORE_DEPTH + 1);
   localparam int IDX_W   = $clog2(DATA_BYTES);
   localparam int ADDR_W  = IDX_W + 1;             // bank bit + byte index
   localparam int ACC_W   = CHANNEL_BITS + BYTE_BITS;
   localparam int BITS_W  = $clog2(ACC_W + 1);

   localparam logic [7:0] FRAME_HEAD = 8'h0F;
   localparam logic [7:0] FRAME_TAIL = 8'h00;

   // Frame buffer write from the front end.
   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [7:0]        data;
   } wr_type;

   // Frame handoff / release of one buffer bank.
   typedef struct packed {
      logic en;
      logic bank;
   } bank_msg_type;

endpackage

/* design/sbus_frame_decoder_core.sv */
// ---------------------------------------------------------------------------
// sbus_frame_decoder_core
// SBUS 16-channel frame decoder, top level.
// ---------------------------------------------------------------------------
// Takes one received byte per accepted item. Bytes are discarded until the
// start byte 0x0F; the next 23 bytes form the frame body and the 25th must be
// 0x00, otherwise the frame is dropped with no output. A good frame yields
// NUM_CHANNELS channel items (index, raw 11-bit value, last flag) in channel
// order. Input bytes are taken one per cycle; two frame buffer banks let a new
// frame be received while the previous one is unpacked, and req_stall rises
// only when a new frame starts while both banks still wait for the unpacker.
// The unpacker reads one buffer byte at a time through a registered memory
// read (S_READ, then S_LOAD) and emits each channel from S_EMIT when the
// output is free, so rsp_stall can hold the drain of a frame.
module sbus_frame_decoder_core #(
   parameter int NUM_CHANNELS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_channel_index,
   output logic [10:0] rsp_channel_value,
   output logic        rsp_last_channel
);
   import sfd_pkg::*;

`include "assert_macros.svh"

   wr_type       wr;
   bank_msg_type push;
   bank_msg_type release_bank;
   logic         q_valid;
   logic         q_bank;
   logic         q_full;
   logic         q_pop;

   sfd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_rx_byte  (req_rx_byte),
      .wr           (wr),
      .push         (push),
      .release_bank (release_bank)
   );

   sfd_cmd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .pop     (q_pop),
      .q_valid (q_valid),
      .q_bank  (q_bank),
      .q_full  (q_full)
   );

   sfd_back #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .wr                (wr),
      .q_valid           (q_valid),
      .q_bank            (q_bank),
      .q_pop             (q_pop),
      .release_bank      (release_bank),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_last_channel  (rsp_last_channel)
   );

   // bank ownership keeps the queue from overflowing
   `SFD_ASSERT(a_no_push_full, clock, reset, !(push.en && q_full), "frame pushed into full queue")

   `SFD_ASSERT_NEXT(a_push_visible, clock, reset, push.en, q_valid, "pushed frame not visible")

   `SFD_ASSERT(a_last_index, clock, reset, !(rsp_valid && rsp_last_channel) || (rsp_channel_index == 4'(NUM_CHANNELS - 1)), "last flag on wrong channel")

endmodule

/* design/sfd_front.sv */
// ---------------------------------------------------------------------------
// sfd_front
// Byte hunter and framer: finds the start byte, writes the channel bytes
// into a free buffer bank and hands good frames to the queue.
// ---------------------------------------------------------------------------
module sfd_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_rx_byte,
   output sfd_pkg::wr_type       wr,
   output sfd_pkg::bank_msg_type push,
   input  sfd_pkg::bank_msg_type release_bank
);
   import sfd_pkg::*;

   logic               in_frame_ff, in_frame_in;
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic               wr_bank_ff, wr_bank_in;
   logic [1:0]         busy_ff, busy_in;
   logic               accept;

   // A bank still owned by the back end cannot take a new frame.
   assign req_stall = in_frame_ff && busy_ff[wr_bank_ff];
   assign accept    = req_valid && !req_stall;

   always_comb begin
      in_frame_in   = in_frame_ff;
      byte_count_in = byte_count_ff;
      wr_bank_in    = wr_bank_ff;
      busy_in       = busy_ff;
      wr.en         = 1'b0;
      wr.addr       = {wr_bank_ff, byte_count_ff[IDX_W-1:0]};
      wr.data       = req_rx_byte;
      push.en       = 1'b0;
      push.bank     = wr_bank_ff;

      if (release_bank.en) begin
         busy_in[release_bank.bank] = 1'b0;
      end

      if (accept) begin
         if (!in_frame_ff) begin
            if (req_rx_byte == FRAME_HEAD) begin
               in_frame_in   = 1'b1;
               byte_count_in = '0;
            end
         end else if (byte_count_ff < COUNT_W'(STORE_DEPTH)) begin
            // flags byte is counted but not kept
            wr.en         = byte_count_ff < COUNT_W'(DATA_BYTES);
            byte_count_in = byte_count_ff + COUNT_W'(1);
         end else begin
            in_frame_in   = 1'b0;
            byte_count_in = '0;
            if (req_rx_byte == FRAME_TAIL) begin
               push.en             = 1'b1;
               busy_in[wr_bank_ff] = 1'b1;
               wr_bank_in          = !wr_bank_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff   <= 1'b0;
         byte_count_ff <= '0;
         wr_bank_ff    <= 1'b0;
         busy_ff       <= '0;
      end else begin
         in_frame_ff   <= in_frame_in;
         byte_count_ff <= byte_count_in;
         wr_bank_ff    <= wr_bank_in;
         busy_ff       <= busy_in;
      end
   end

endmodule

/* design/sfd_cmd_queue.sv */
// ---------------------------------------------------------------------------
// sfd_cmd_queue
// Two-entry queue of finished frame banks between front and back end.
// ---------------------------------------------------------------------------
module sfd_cmd_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  sfd_pkg::bank_msg_type push,
   input  logic                  pop,
   output logic                  q_valid,
   output logic                  q_bank,
   output logic                  q_full
);
   import sfd_pkg::*;

   logic [1:0] slot_ff, slot_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_pop;

   assign q_valid = count_ff != 2'd0;
   assign q_full  = count_ff == 2'd2;
   assign q_bank  = slot_ff[rd_ptr_ff];
   assign do_pop  = pop && q_valid;

   always_comb begin
      slot_in   = slot_ff;
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push.en) begin
         slot_in[wr_ptr_ff] = push.bank;
         wr_ptr_in          = !wr_ptr_ff;
      end
      if (do_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      unique case ({push.en, do_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* design/sfd_back.sv */
// ---------------------------------------------------------------------------
// sfd_back
// Channel unpacker: holds the two frame buffer banks, reads one byte at a
// time into a bit accumulator and emits an 11-bit channel when enough bits
// are in.
// ---------------------------------------------------------------------------
module sfd_back #(
   parameter int NUM_CHANNELS = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sfd_pkg::wr_type       wr,
   input  logic                  q_valid,
   input  logic                  q_bank,
   output logic                  q_pop,
   output sfd_pkg::bank_msg_type release_bank,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [3:0]            rsp_channel_index,
   output logic [10:0]           rsp_channel_value,
   output logic                  rsp_last_channel
);
   import sfd_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_READ,
      S_LOAD,
      S_EMIT
   } state_type;

   localparam logic [3:0] LAST_CH = 4'(NUM_CHANNELS - 1);

   logic [7:0]        frame_mem_ff [0:(1 << ADDR_W) - 1];
   logic [7:0]        rd_data_ff;

   state_type         state_ff;
   logic              bank_ff;
   logic [IDX_W-1:0]  byte_idx_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [BITS_W-1:0] bits_ff;
   logic [3:0]        ch_ff;
   logic              rsp_valid_ff;
   logic [3:0]        rsp_index_ff;
   logic [10:0]       rsp_value_ff;
   logic              rsp_last_ff;
   logic              release_en_ff;
   logic              out_free;
   logic [BITS_W-1:0] bits_loaded;

   assign q_pop             = (state_ff == S_IDLE) && q_valid;
   assign out_free          = !rsp_valid_ff || !rsp_stall;
   assign bits_loaded       = bits_ff + BITS_W'(BYTE_BITS);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_channel_index = rsp_index_ff;
   assign rsp_channel_value = rsp_value_ff;
   assign rsp_last_channel  = rsp_last_ff;
   assign release_bank.en   = release_en_ff;
   assign release_bank.bank = bank_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         frame_mem_ff[wr.addr] <= wr.data;
      end
      rd_data_ff <= frame_mem_ff[{bank_ff, byte_idx_ff}];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         release_en_ff <= 1'b0;
      end else begin
         // bank is handed back right after its last channel goes out
         release_en_ff <= (state_ff == S_EMIT) && out_free && (ch_ff == LAST_CH);
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  bank_ff     <= q_bank;
                  byte_idx_ff <= '0;
                  acc_ff      <= '0;
                  bits_ff     <= '0;
                  ch_ff       <= '0;
                  state_ff    <= S_READ;
               end
            end
            S_READ: begin
               // memory read of byte_idx_ff lands in rd_data_ff
               state_ff <= S_LOAD;
            end
            S_LOAD: begin
               acc_ff      <= acc_ff | (ACC_W'(rd_data_ff) << bits_ff);
               bits_ff     <= bits_loaded;
               byte_idx_ff <= byte_idx_ff + IDX_W'(1);
               state_ff    <= (bits_loaded >= BITS_W'(CHANNEL_BITS)) ? S_EMIT : S_READ;
            end
            S_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_index_ff <= ch_ff;
                  rsp_value_ff <= acc_ff[CHANNEL_BITS-1:0];
                  rsp_last_ff  <= ch_ff == LAST_CH;
                  acc_ff       <= acc_ff >> CHANNEL_BITS;
                  bits_ff      <= bits_ff - BITS_W'(CHANNEL_BITS);
                  ch_ff        <= ch_ff + 4'd1;
                  if (ch_ff == LAST_CH) begin
                     state_ff <= S_IDLE;
                  end else begin
                     state_ff <= S_READ;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule
